### sv/mws_pkg.sv
// Shared constants and types for the morphing waveform shaper.
`default_nettype none
package mws_pkg;
  localparam int SINE_B = 19900;
  localparam int SINE_C = 3516;
  localparam int SINE_ONE = 4096;

  localparam logic [31:0] TRI_OFFSET = 32'h4000_0000;
  localparam logic [31:0] PULSE_HI = 32'h1FFF_FFFF;
  localparam logic [31:0] PULSE_LO = 32'hE000_0000;
  localparam logic [7:0] FRAC_MAX = 8'd255;

  localparam int DIV_W = 11;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = 32 / BITS_PER_STAGE;

  localparam logic ADDR_COMP_MIN = 1'b0;
  localparam logic ADDR_COMP_MUL = 1'b1;

  typedef struct packed {
    logic              vld;
    logic              neg;
    logic [DIV_W-1:0]  rem;
    logic [31:0]       work;
    logic [31:0]       raw;
  } div_stage_t;
endpackage
`default_nettype wire

### sv/morphing_waveform_shaper.sv
// Top level: shape generation, crossfade and compensation divide pipeline.
// Pipeline: 14 pipeline stages plus the output register lie between the input
// transaction and out_tvalid; the divide is 8 stages of 4 restoring steps.
// Throughput: one transaction per cycle while in_tready is high; a 2-entry output buffer absorbs stalls.
// Reset (rst_n low, synchronous): pipeline empty, comp_min = 0,
// comp_mul = 0x100000.
`default_nettype none
module morphing_waveform_shaper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // phase[31:0], morph[39:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,   // sample[31:0], raw_sample[63:32]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // configuration
  logic [31:0] comp_min_r;
  logic [30:0] comp_mul_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == mws_pkg::ADDR_COMP_MUL) ? {1'b0, comp_mul_r} : comp_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_min_r <= 32'd0;
      comp_mul_r <= 31'd1048576;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == mws_pkg::ADDR_COMP_MIN) comp_min_r <= cfg_pwdata;
      else comp_mul_r <= cfg_pwdata[30:0];
    end
  end

  logic [mws_pkg::DIV_W-1:0] divisor;
  assign divisor = (comp_mul_r[30:20] == 11'd0) ? 11'd1 : comp_mul_r[30:20];

  // flow control
  logic skid_v_r;
  logic en;
  assign en = ~skid_v_r;
  assign in_tready = en;

  // stage 1 combinational
  logic [31:0] phase;
  logic [7:0]  morph;
  logic [13:0] d14;
  logic signed [13:0] xs;
  logic signed [27:0] xsq;
  logic [9:0]  t3;
  logic [7:0]  frac_c;
  logic [1:0]  idx_c;
  logic [31:0] tri_v;
  logic [31:0] tri_d;

  assign phase = in_tdata[31:0];
  assign morph = in_tdata[39:32];
  assign d14 = phase[30:17] - 14'h2000;
  assign xs = $signed(d14);
  assign xsq = 28'(xs) * 28'(xs);
  assign t3 = {2'b00, morph} + {1'b0, morph, 1'b0};
  assign frac_c = (t3[7:0] != 8'd0 && t3[7:0] != mws_pkg::FRAC_MAX) ? t3[7:0] + 8'd1 : t3[7:0];
  assign idx_c = (t3[9:8] == 2'd3) ? 2'd2 : t3[9:8];
  assign tri_v = phase[31] ? ~phase : phase;
  assign tri_d = tri_v - mws_pkg::TRI_OFFSET;

  logic        v1_r, neg1_r, p31_1_r;
  logic [14:0] x2_1_r;
  logic [31:0] tri1_r, saw1_r;
  logic [7:0]  frac1_r;
  logic [1:0]  idx1_r;

  // stage 2
  logic [25:0] x2c;
  logic [15:0] y1_c;
  assign x2c = 26'(x2_1_r) * 26'(mws_pkg::SINE_C);
  assign y1_c = 16'(mws_pkg::SINE_B) - {4'd0, x2c[25:14]};

  logic        v2_r, neg2_r, p31_2_r;
  logic [14:0] x2_2_r;
  logic [15:0] y1_2_r;
  logic [31:0] tri2_r, saw2_r;
  logic [7:0]  frac2_r;
  logic [1:0]  idx2_r;

  // stage 3
  logic [30:0] x2y;
  logic [31:0] y_c;
  logic [31:0] sine_c;
  assign x2y = 31'(x2_2_r) * 31'(y1_2_r);
  assign y_c = 32'(mws_pkg::SINE_ONE) - {17'd0, x2y[30:16]};
  assign sine_c = (neg2_r ? (32'd0 - y_c) : y_c) << 17;

  logic        v3_r, p31_3_r;
  logic [31:0] sine3_r, tri3_r, saw3_r;
  logic [7:0]  frac3_r;
  logic [1:0]  idx3_r;

  // stage 4: shape selection
  logic [31:0] pulse3, sh_a, sh_b;
  assign pulse3 = p31_3_r ? mws_pkg::PULSE_LO : mws_pkg::PULSE_HI;
  always_comb begin
    case (idx3_r)
      2'd0: begin sh_a = sine3_r; sh_b = tri3_r; end
      2'd1: begin sh_a = tri3_r;  sh_b = saw3_r; end
      default: begin sh_a = saw3_r; sh_b = pulse3; end
    endcase
  end

  logic               v4_r;
  logic signed [23:0] a4_r, b4_r;
  logic [7:0]         frac4_r;

  // stage 5: crossfade
  logic signed [33:0] pa, pb;
  logic signed [33:0] mix_c;
  assign pa = 34'(a4_r) * 34'($signed({2'b00, mws_pkg::FRAC_MAX - frac4_r}));
  assign pb = 34'(b4_r) * 34'($signed({2'b00, frac4_r}));
  assign mix_c = pa + pb;

  logic        v5_r;
  logic [31:0] raw5_r;

  // stage 6: offset and magnitude
  logic [31:0] diff_c;
  assign diff_c = raw5_r - comp_min_r;

  logic        v6_r, neg6_r;
  logic [31:0] raw6_r, mag6_r;

  // restoring divide, 4 quotient bits per stage
  mws_pkg::div_stage_t dv_r   [mws_pkg::DIV_STAGES];
  mws_pkg::div_stage_t dv_nxt [mws_pkg::DIV_STAGES];

  always_comb begin
    mws_pkg::div_stage_t cur;
    logic [mws_pkg::DIV_W:0] r12;
    for (int s = 0; s < mws_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        cur.vld = v6_r;
        cur.neg = neg6_r;
        cur.rem = '0;
        cur.work = mag6_r;
        cur.raw = raw6_r;
      end else begin
        cur = dv_r[s-1];
      end
      for (int k = 0; k < mws_pkg::BITS_PER_STAGE; k++) begin
        r12 = {cur.rem, cur.work[31]};
        if (r12 >= {1'b0, divisor}) begin
          r12 = r12 - {1'b0, divisor};
          cur.work = {cur.work[30:0], 1'b1};
        end else begin
          cur.work = {cur.work[30:0], 1'b0};
        end
        cur.rem = r12[mws_pkg::DIV_W-1:0];
      end
      dv_nxt[s] = cur;
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= phase[31];
      p31_1_r <= phase[31];
      x2_1_r  <= xsq[26:12];
      tri1_r  <= 32'($signed(tri_d) >>> 1);
      saw1_r  <= 32'($signed(phase) >>> 2);
      frac1_r <= frac_c;
      idx1_r  <= idx_c;

      neg2_r <= neg1_r; p31_2_r <= p31_1_r; x2_2_r <= x2_1_r; y1_2_r <= y1_c;
      tri2_r <= tri1_r; saw2_r <= saw1_r; frac2_r <= frac1_r; idx2_r <= idx1_r;

      p31_3_r <= p31_2_r; sine3_r <= sine_c; tri3_r <= tri2_r; saw3_r <= saw2_r;
      frac3_r <= frac2_r; idx3_r <= idx2_r;

      a4_r <= $signed(sh_a[31:8]);
      b4_r <= $signed(sh_b[31:8]);
      frac4_r <= frac3_r;

      raw5_r <= mix_c[31:0];

      raw6_r <= raw5_r;
      neg6_r <= diff_c[31];
      mag6_r <= diff_c[31] ? (32'd0 - diff_c) : diff_c;

      for (int s = 0; s < mws_pkg::DIV_STAGES; s++) begin
        dv_r[s].neg  <= dv_nxt[s].neg;
        dv_r[s].rem  <= dv_nxt[s].rem;
        dv_r[s].work <= dv_nxt[s].work;
        dv_r[s].raw  <= dv_nxt[s].raw;
      end
    end
    for (int s = 0; s < mws_pkg::DIV_STAGES; s++) begin
      if (!rst_n) dv_r[s].vld <= 1'b0;
      else if (en) dv_r[s].vld <= dv_nxt[s].vld;
    end
  end

  // result and output buffering
  mws_pkg::div_stage_t last;
  logic [31:0] quo;
  logic [63:0] res;
  logic        push, take;
  assign last = dv_r[mws_pkg::DIV_STAGES-1];
  assign quo = last.neg ? (32'd0 - last.work) : last.work;
  assign res = {last.raw, quo[21:0], 10'd0};
  assign push = en & last.vld;
  assign take = out_tvalid & out_tready;

  logic        out_v_r;
  logic [63:0] out_d_r, skid_d_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || take) begin
      out_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) out_d_r <= skid_d_r;
    end else if (!out_v_r || take) begin
      out_d_r <= res;
    end else if (push) begin
      skid_d_r <= res;
    end
  end

endmodule
`default_nettype wire
